// ===== rtl/core/hpc_pkg.sv =====
`default_nettype none
package hpc_pkg;

   localparam int ENTRIES = 64;
   localparam int BUCKETS = 128;    // power of two, hash is the low port bits

   localparam int LINK_W  = $clog2(ENTRIES + 1);
   localparam int IDX_W   = $clog2(ENTRIES);
   localparam int BKT_W   = $clog2(BUCKETS);
   localparam int CNT_W   = $clog2(ENTRIES + 1);
   localparam int IDLE_W  = 32;
   localparam int SUM_W   = IDLE_W + $clog2(ENTRIES);
   localparam int CLR_N   = (BUCKETS > ENTRIES) ? BUCKETS : ENTRIES;
   localparam int CLR_W   = $clog2(CLR_N + 1);
   localparam int PURGE_MIN = (3 * ENTRIES) >> 2;

   localparam logic [LINK_W-1:0] NIL      = LINK_W'(ENTRIES);
   localparam logic [IDLE_W-1:0] IDLE_MAX = '1;

   localparam logic [2:0] FN_INSTALL = 3'd0;
   localparam logic [2:0] FN_LOOKUP  = 3'd1;
   localparam logic [2:0] FN_MATCH   = 3'd2;
   localparam logic [2:0] FN_REMOVE  = 3'd3;
   localparam logic [2:0] FN_SWEEP   = 3'd4;

   typedef struct packed {
      logic [2:0]  func;
      logic [47:0] port_key;
      logic [63:0] net_addr;
      logic [15:0] thread_id;
      logic        is_local;
      logic [31:0] round_trip;
      logic [31:0] context_tag;
      logic        owner_only;
   } req_type;

   typedef struct packed {
      logic        found;
      logic        status;
      logic [15:0] thread_out;
      logic [63:0] addr_out;
      logic        local_out;
      logic [31:0] round_trip_out;
      logic [31:0] tag_out;
      logic [6:0]  remote_entries;
      logic [31:0] oldest_out;
   } rsp_type;

   typedef struct packed {
      logic [LINK_W-1:0] link;
      logic [47:0]       port;
      logic [63:0]       addr;
      logic [15:0]       thread;
      logic              is_local;
      logic [31:0]       round_trip;
      logic [31:0]       tag;
      logic [IDLE_W-1:0] idle;
   } slot_type;

   localparam int SLOT_W = $bits(slot_type);

   typedef struct packed {
      logic             start;
      logic [SUM_W-1:0] dividend;
      logic [CNT_W-1:0] divisor;
   } div_in_type;

   typedef struct packed {
      logic             done;
      logic [SUM_W-1:0] quotient;
   } div_out_type;

   typedef enum logic [4:0] {
      ST_CLEAR, ST_IDLE, ST_HEAD, ST_HEAD_W, ST_WALK, ST_CHK, ST_REL1, ST_REL2,
      ST_ALLOC, ST_ALLOC_W, ST_SCAN_B, ST_SCAN_BW, ST_SCAN_WALK, ST_SCAN_CHK,
      ST_EVICT, ST_SWEEP, ST_DIV, ST_DONE
   } state_type;

endpackage
`default_nettype wire

// ===== rtl/core/hpc_ram.sv =====
`default_nettype none
module hpc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule
`default_nettype wire

// ===== rtl/core/hpc_div.sv =====
`default_nettype none
module hpc_div
   import hpc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire div_in_type  div_in,
   output div_out_type      div_out
);
   localparam int STEP_W = $clog2(SUM_W + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [SUM_W-1:0]  quo_ff, quo_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [CNT_W-1:0]  dsr_ff, dsr_in;
   logic [CNT_W:0]    trial;

   // restoring, one quotient bit a cycle
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      trial   = {rem_ff, quo_ff[SUM_W-1]};
      if (div_in.start) begin
         busy_in = 1'b1;
         step_in = '0;
         quo_in  = div_in.dividend;
         rem_in  = '0;
         dsr_in  = div_in.divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = CNT_W'(trial - {1'b0, dsr_ff});
            quo_in = {quo_ff[SUM_W-2:0], 1'b1};
         end else begin
            rem_in = CNT_W'(trial);
            quo_in = {quo_ff[SUM_W-2:0], 1'b0};
         end
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(SUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
   end

   assign div_out.done     = done_ff;
   assign div_out.quotient = quo_ff;
endmodule
`default_nettype wire

// ===== rtl/core/hashed_port_cache.sv =====
// Port cache: hash chains over a bucket head memory and a slot memory.
// req_*: one operation beat (install, lookup, match local, remove, sweep tick).
// rsp_*: exactly one result beat per request, in request order.
// One request is in work at a time; req_ready is high only while idle, but a
// finished result waits in the output register so the next request may enter.
// Work per operation, each memory having a single read port:
//   lookup, match, remove, refresh: head read, one slot read per entry visited.
//   install with a free slot: that walk plus the slot allocation.
//   install into a full table: plus a full table scan of every bucket
//   and entry, then a second chain walk.
//   sweep: full table scan, plus a division when purging applies.
// After reset a clearing pass over max(BUCKETS, ENTRIES) addresses sets all
// chains empty and links every slot into the free list; req_ready stays low.
// A stalled rsp_ready holds the result and stops the next operation at its end.
`default_nettype none
module hashed_port_cache
   import hpc_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);
   state_type         state_ff, state_in;
   req_type           req_ff, req_in;
   rsp_type           res_ff, res_in;
   rsp_type           out_ff, out_in;
   logic              outv_ff, outv_in;
   logic [CLR_W-1:0]  clr_ff, clr_in;
   logic [LINK_W-1:0] cur_ff, cur_in;
   logic [LINK_W-1:0] prev_ff, prev_in;
   slot_type          pword_ff, pword_in;
   logic [BKT_W-1:0]  bkt_ff, bkt_in;
   logic [LINK_W-1:0] free_ff, free_in;
   logic [CNT_W-1:0]  rcount_ff, rcount_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [IDLE_W-1:0] oldest_ff, oldest_in;
   logic              purge_ff, purge_in;
   logic [SUM_W-1:0]  avg_ff, avg_in;
   logic [LINK_W-1:0] best_ff, best_in;
   logic [IDLE_W-1:0] bidle_ff, bidle_in;
   logic [47:0]       bport_ff, bport_in;
   logic [63:0]       baddr_ff, baddr_in;
   logic [BKT_W-1:0]  bbkt_ff, bbkt_in;
   logic              evict2_ff, evict2_in;

   logic              bk_wr_en, bk_rd_en;
   logic [BKT_W-1:0]  bk_wr_addr, bk_rd_addr;
   logic [LINK_W-1:0] bk_wr_data, bk_rd_data;
   logic              sl_wr_en, sl_rd_en;
   logic [IDX_W-1:0]  sl_wr_addr, sl_rd_addr;
   slot_type          sl_wr_data, sl_rd_data;
   logic [SLOT_W-1:0] sl_rd_raw;

   div_in_type        dv_in;
   div_out_type       dv_out;

   hpc_ram #(.WIDTH(LINK_W), .DEPTH(BUCKETS)) u_bucket (
      .clock  (clock),
      .wr_en  (bk_wr_en),
      .wr_addr(bk_wr_addr),
      .wr_data(bk_wr_data),
      .rd_en  (bk_rd_en),
      .rd_addr(bk_rd_addr),
      .rd_data(bk_rd_data)
   );

   hpc_ram #(.WIDTH(SLOT_W), .DEPTH(ENTRIES)) u_slot (
      .clock  (clock),
      .wr_en  (sl_wr_en),
      .wr_addr(sl_wr_addr),
      .wr_data(sl_wr_data),
      .rd_en  (sl_rd_en),
      .rd_addr(sl_rd_addr),
      .rd_data(sl_rd_raw)
   );

   assign sl_rd_data = sl_rd_raw;

   hpc_div u_div (
      .clock  (clock),
      .reset  (reset),
      .div_in (dv_in),
      .div_out(dv_out)
   );

   always_comb begin
      slot_type          w;
      slot_type          aged;
      logic [BKT_W-1:0]  hash;
      logic              pe, ae, hit;

      state_in  = state_ff;
      req_in    = req_ff;
      res_in    = res_ff;
      out_in    = out_ff;
      outv_in   = outv_ff;
      clr_in    = clr_ff;
      cur_in    = cur_ff;
      prev_in   = prev_ff;
      pword_in  = pword_ff;
      bkt_in    = bkt_ff;
      free_in   = free_ff;
      rcount_in = rcount_ff;
      sum_in    = sum_ff;
      oldest_in = oldest_ff;
      purge_in  = purge_ff;
      avg_in    = avg_ff;
      best_in   = best_ff;
      bidle_in  = bidle_ff;
      bport_in  = bport_ff;
      baddr_in  = baddr_ff;
      bbkt_in   = bbkt_ff;
      evict2_in = evict2_ff;

      bk_wr_en   = 1'b0;
      bk_wr_addr = bkt_ff;
      bk_wr_data = '0;
      bk_rd_en   = 1'b0;
      bk_rd_addr = bkt_ff;
      sl_wr_en   = 1'b0;
      sl_wr_addr = cur_ff[IDX_W-1:0];
      sl_wr_data = sl_rd_data;
      sl_rd_en   = 1'b0;
      sl_rd_addr = cur_ff[IDX_W-1:0];

      dv_in.start    = 1'b0;
      dv_in.dividend = sum_ff;
      dv_in.divisor  = rcount_ff;

      req_ready = (state_ff == ST_IDLE);

      w    = sl_rd_data;
      aged = w;
      if (w.idle != IDLE_MAX) begin
         aged.idle = w.idle + 1'b1;
      end
      hash = req_ff.port_key[BKT_W-1:0];
      pe   = (w.port == req_ff.port_key);
      ae   = (w.addr == req_ff.net_addr);
      hit  = 1'b0;

      if (outv_ff && rsp_ready) begin
         outv_in = 1'b0;
      end

      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff < CLR_W'(BUCKETS)) begin
               bk_wr_en   = 1'b1;
               bk_wr_addr = BKT_W'(clr_ff);
               bk_wr_data = NIL;
            end
            if (clr_ff < CLR_W'(ENTRIES)) begin
               sl_wr_en        = 1'b1;
               sl_wr_addr      = IDX_W'(clr_ff);
               sl_wr_data      = '0;
               sl_wr_data.link = LINK_W'(clr_ff) + 1'b1;
            end
            clr_in = clr_ff + 1'b1;
            if (clr_ff == CLR_W'(CLR_N - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               req_in    = req_data;
               res_in    = '0;
               bkt_in    = req_data.port_key[BKT_W-1:0];
               evict2_in = 1'b0;
               case (req_data.func)
                  FN_INSTALL, FN_LOOKUP, FN_MATCH, FN_REMOVE: state_in = ST_HEAD;
                  FN_SWEEP: state_in = ST_SWEEP;
                  default:  state_in = ST_DONE;
               endcase
            end
         end
         ST_HEAD: begin
            bk_rd_en = 1'b1;
            state_in = ST_HEAD_W;
         end
         ST_HEAD_W: begin
            cur_in   = bk_rd_data;
            prev_in  = NIL;
            state_in = ST_WALK;
         end
         ST_WALK: begin
            if (cur_ff >= NIL) begin
               if (req_ff.func == FN_INSTALL && !evict2_ff) begin
                  if (free_ff < NIL) begin
                     state_in = ST_ALLOC;
                  end else begin
                     best_in  = NIL;
                     bkt_in   = '0;
                     state_in = ST_SCAN_B;
                  end
               end else begin
                  state_in = ST_DONE;
               end
            end else begin
               sl_rd_en = 1'b1;
               state_in = ST_CHK;
            end
         end
         ST_CHK: begin
            if (evict2_ff) begin
               if (!w.is_local && w.port == bport_ff && w.addr == baddr_ff) begin
                  hit      = 1'b1;
                  state_in = ST_REL1;
               end
            end else begin
               case (req_ff.func)
                  FN_INSTALL: begin
                     if (pe && ae && w.thread == req_ff.thread_id) begin
                        hit                   = 1'b1;
                        sl_wr_en              = 1'b1;
                        sl_wr_data.round_trip = req_ff.round_trip;
                        sl_wr_data.is_local   = req_ff.is_local;
                        sl_wr_data.idle       = '0;
                        sl_wr_data.tag        = req_ff.context_tag;
                        res_in.found          = 1'b1;
                        state_in              = ST_DONE;
                     end
                  end
                  FN_LOOKUP: begin
                     if (pe) begin
                        hit                   = 1'b1;
                        sl_wr_en              = 1'b1;
                        sl_wr_data.idle       = '0;
                        res_in.found          = 1'b1;
                        res_in.thread_out     = w.thread;
                        res_in.addr_out       = w.addr;
                        res_in.local_out      = w.is_local;
                        res_in.round_trip_out = w.round_trip;
                        res_in.tag_out        = w.tag;
                        state_in              = ST_DONE;
                     end
                  end
                  FN_MATCH: begin
                     if (pe && ae && w.is_local) begin
                        hit               = 1'b1;
                        res_in.found      = 1'b1;
                        res_in.thread_out = w.thread;
                        state_in          = ST_REL1;
                     end
                  end
                  FN_REMOVE: begin
                     if (pe && ae && ((req_ff.owner_only && w.thread == req_ff.thread_id)
                                      || !w.is_local)) begin
                        hit      = 1'b1;
                        state_in = ST_REL1;
                     end
                  end
                  default: begin
                     hit      = 1'b1;
                     state_in = ST_DONE;
                  end
               endcase
            end
            if (!hit) begin
               prev_in  = cur_ff;
               pword_in = w;
               cur_in   = w.link;
               state_in = ST_WALK;
            end
         end
         ST_REL1: begin
            if (prev_ff >= NIL) begin
               bk_wr_en   = 1'b1;
               bk_wr_data = w.link;
            end else begin
               sl_wr_en        = 1'b1;
               sl_wr_addr      = prev_ff[IDX_W-1:0];
               sl_wr_data      = pword_ff;
               sl_wr_data.link = w.link;
            end
            pword_in.link = w.link;
            state_in      = ST_REL2;
         end
         ST_REL2: begin
            sl_wr_en        = 1'b1;
            sl_wr_data.link = free_ff;
            free_in         = cur_ff;
            case (req_ff.func)
               FN_SWEEP: begin
                  cur_in   = w.link;
                  state_in = ST_SCAN_WALK;
               end
               FN_INSTALL: state_in = ST_ALLOC;
               default:    state_in = ST_DONE;
            endcase
         end
         ST_ALLOC: begin
            bk_rd_en   = 1'b1;
            bk_rd_addr = hash;
            sl_rd_en   = 1'b1;
            sl_rd_addr = free_ff[IDX_W-1:0];
            state_in   = ST_ALLOC_W;
         end
         ST_ALLOC_W: begin
            sl_wr_en              = 1'b1;
            sl_wr_addr            = free_ff[IDX_W-1:0];
            sl_wr_data.link       = bk_rd_data;
            sl_wr_data.port       = req_ff.port_key;
            sl_wr_data.addr       = req_ff.net_addr;
            sl_wr_data.thread     = req_ff.thread_id;
            sl_wr_data.is_local   = req_ff.is_local;
            sl_wr_data.round_trip = req_ff.round_trip;
            sl_wr_data.tag        = req_ff.context_tag;
            sl_wr_data.idle       = '0;
            bk_wr_en              = 1'b1;
            bk_wr_addr            = hash;
            bk_wr_data            = free_ff;
            free_in               = w.link;
            state_in              = ST_DONE;
         end
         ST_SCAN_B: begin
            bk_rd_en = 1'b1;
            state_in = ST_SCAN_BW;
         end
         ST_SCAN_BW: begin
            cur_in   = bk_rd_data;
            prev_in  = NIL;
            state_in = ST_SCAN_WALK;
         end
         ST_SCAN_WALK: begin
            if (cur_ff >= NIL) begin
               if (bkt_ff == BKT_W'(BUCKETS - 1)) begin
                  if (req_ff.func == FN_SWEEP) begin
                     res_in.remote_entries = 7'(rcount_ff);
                     res_in.oldest_out     = oldest_ff;
                     state_in              = ST_DONE;
                  end else begin
                     state_in = ST_EVICT;
                  end
               end else begin
                  bkt_in   = bkt_ff + 1'b1;
                  state_in = ST_SCAN_B;
               end
            end else begin
               sl_rd_en = 1'b1;
               state_in = ST_SCAN_CHK;
            end
         end
         ST_SCAN_CHK: begin
            if (req_ff.func == FN_SWEEP) begin
               if (purge_ff && !w.is_local && {{(SUM_W-IDLE_W){1'b0}}, aged.idle} >= avg_ff)
               begin
                  state_in = ST_REL1;
               end else begin
                  sl_wr_en   = 1'b1;
                  sl_wr_data = aged;
                  if (!w.is_local) begin
                     rcount_in = rcount_ff + 1'b1;
                     sum_in    = sum_ff + SUM_W'(aged.idle);
                     if (aged.idle > oldest_ff) begin
                        oldest_in = aged.idle;
                     end
                  end
                  prev_in  = cur_ff;
                  pword_in = aged;
                  cur_in   = w.link;
                  state_in = ST_SCAN_WALK;
               end
            end else begin
               if (!w.is_local && (best_ff >= NIL || bidle_ff < w.idle)) begin
                  best_in  = cur_ff;
                  bidle_in = w.idle;
                  bport_in = w.port;
                  baddr_in = w.addr;
                  bbkt_in  = bkt_ff;
               end
               cur_in   = w.link;
               state_in = ST_SCAN_WALK;
            end
         end
         ST_EVICT: begin
            if (best_ff >= NIL) begin
               res_in.status = 1'b1;
               state_in      = ST_DONE;
            end else begin
               bkt_in    = bbkt_ff;
               evict2_in = 1'b1;
               state_in  = ST_HEAD;
            end
         end
         ST_SWEEP: begin
            rcount_in = '0;
            sum_in    = '0;
            oldest_in = '0;
            bkt_in    = '0;
            if (rcount_ff >= CNT_W'(PURGE_MIN) && rcount_ff != '0) begin
               dv_in.start = 1'b1;
               purge_in    = 1'b1;
               state_in    = ST_DIV;
            end else begin
               purge_in = 1'b0;
               state_in = ST_SCAN_B;
            end
         end
         ST_DIV: begin
            if (dv_out.done) begin
               avg_in   = dv_out.quotient;
               state_in = ST_SCAN_B;
            end
         end
         ST_DONE: begin
            if (!outv_ff || rsp_ready) begin
               outv_in  = 1'b1;
               out_in   = res_ff;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLEAR;
         clr_ff    <= '0;
         outv_ff   <= 1'b0;
         free_ff   <= '0;
         rcount_ff <= '0;
         sum_ff    <= '0;
         oldest_ff <= '0;
         evict2_ff <= 1'b0;
         purge_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         clr_ff    <= clr_in;
         outv_ff   <= outv_in;
         free_ff   <= free_in;
         rcount_ff <= rcount_in;
         sum_ff    <= sum_in;
         oldest_ff <= oldest_in;
         evict2_ff <= evict2_in;
         purge_ff  <= purge_in;
      end
      req_ff   <= req_in;
      res_ff   <= res_in;
      out_ff   <= out_in;
      cur_ff   <= cur_in;
      prev_ff  <= prev_in;
      pword_ff <= pword_in;
      bkt_ff   <= bkt_in;
      avg_ff   <= avg_in;
      best_ff  <= best_in;
      bidle_ff <= bidle_in;
      bport_ff <= bport_in;
      baddr_ff <= baddr_in;
      bbkt_ff  <= bbkt_in;
   end

   assign rsp_valid = outv_ff;
   assign rsp_data  = out_ff;
endmodule
`default_nettype wire

// ===== dv/hashed_port_cache_test.sv =====
module hashed_port_cache_test;
   import hpc_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 200000;
   localparam int RANDOM_ITEMS = 1240;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;

   hashed_port_cache u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // cache shadow
   logic [6:0]  sh_bucket[BUCKETS];
   logic [6:0]  sh_free;
   logic [6:0]  sh_next[ENTRIES];
   logic [47:0] sh_port[ENTRIES];
   logic [63:0] sh_addr[ENTRIES];
   logic [15:0] sh_thread[ENTRIES];
   logic        sh_local[ENTRIES];
   logic [31:0] sh_rt[ENTRIES];
   logic [31:0] sh_tag[ENTRIES];
   logic [31:0] sh_idle[ENTRIES];
   int unsigned sh_remote;
   longint unsigned sh_sum;
   logic [31:0] sh_oldest;

   req_type pending_beats[$];
   rsp_type expected_rsps[$];
   int      mismatches = 0;
   int      beats_in = 0;
   int      beats_out = 0;
   int      hits = 0;
   int      sweeps_seen = 0;
   int      full_fails = 0;
   bit      hold_off = 1'b0;
   bit      quiet = 1'b0;

   localparam logic [6:0] END_LINK = 7'(ENTRIES);

   function automatic void shadow_reset();
      for (int i = 0; i < BUCKETS; i++) sh_bucket[i] = END_LINK;
      for (int i = 0; i < ENTRIES; i++) begin
         sh_next[i] = 7'(i + 1);
         sh_port[i] = '0; sh_addr[i] = '0; sh_thread[i] = '0; sh_local[i] = 1'b0;
         sh_rt[i] = '0; sh_tag[i] = '0; sh_idle[i] = '0;
      end
      sh_free = 7'd0;
      sh_remote = 0;
      sh_sum = 0;
      sh_oldest = '0;
   endfunction

   function automatic void unlink_slot(int b, logic [6:0] prev, logic [6:0] cur);
      logic [6:0] nxt;
      nxt = sh_next[cur];
      if (prev == END_LINK) sh_bucket[b] = nxt;
      else sh_next[prev] = nxt;
      sh_next[cur] = sh_free;
      sh_free = cur;
   endfunction

   function automatic bit evict_remote();
      logic [6:0] best, c, p;
      int bb;
      best = END_LINK;
      bb = 0;
      for (int b = 0; b < BUCKETS; b++)
         for (c = sh_bucket[b]; c < END_LINK; c = sh_next[c])
            if (!sh_local[c] && (best == END_LINK || sh_idle[best] < sh_idle[c])) begin
               best = c;
               bb = b;
            end
      if (best == END_LINK) return 1'b0;
      p = END_LINK;
      for (c = sh_bucket[bb]; c < END_LINK; c = sh_next[c]) begin
         if (sh_port[c] == sh_port[best] && sh_addr[c] == sh_addr[best] && !sh_local[c]) begin
            unlink_slot(bb, p, c);
            return 1'b1;
         end
         p = c;
      end
      return 1'b1;
   endfunction

   function automatic void age_and_purge();
      bit purge;
      longint unsigned avg;
      logic [6:0] c, p, nxt;
      purge = 1'b0;
      avg = 0;
      if (sh_remote >= PURGE_MIN && sh_remote > 0) begin
         avg = sh_sum / sh_remote;
         purge = 1'b1;
      end
      sh_remote = 0;
      sh_sum = 0;
      sh_oldest = '0;
      for (int b = 0; b < BUCKETS; b++) begin
         p = END_LINK;
         c = sh_bucket[b];
         while (c < END_LINK) begin
            nxt = sh_next[c];
            if (sh_idle[c] != IDLE_MAX) sh_idle[c]++;
            if (purge && !sh_local[c] && longint'(sh_idle[c]) >= avg) unlink_slot(b, p, c);
            else begin
               if (!sh_local[c]) begin
                  sh_remote++;
                  sh_sum += sh_idle[c];
                  if (sh_idle[c] > sh_oldest) sh_oldest = sh_idle[c];
               end
               p = c;
            end
            c = nxt;
         end
      end
   endfunction

   function automatic rsp_type cache_result(req_type r);
      rsp_type o;
      int b;
      logic [6:0] c, p;
      o = '0;
      b = int'(r.port_key[6:0]);
      case (r.func)
         FN_INSTALL: begin
            for (c = sh_bucket[b]; c < END_LINK; c = sh_next[c])
               if (sh_port[c] == r.port_key && sh_addr[c] == r.net_addr &&
                   sh_thread[c] == r.thread_id) begin
                  sh_rt[c] = r.round_trip; sh_local[c] = r.is_local;
                  sh_idle[c] = '0; sh_tag[c] = r.context_tag;
                  o.found = 1'b1;
                  return o;
               end
            if (sh_free == END_LINK && (!evict_remote() || sh_free == END_LINK)) begin
               o.status = 1'b1;
               return o;
            end
            c = sh_free;
            sh_free = sh_next[c];
            sh_next[c] = sh_bucket[b];
            sh_bucket[b] = c;
            sh_port[c] = r.port_key; sh_addr[c] = r.net_addr; sh_thread[c] = r.thread_id;
            sh_local[c] = r.is_local; sh_rt[c] = r.round_trip; sh_tag[c] = r.context_tag;
            sh_idle[c] = '0;
         end
         FN_LOOKUP: begin
            for (c = sh_bucket[b]; c < END_LINK; c = sh_next[c])
               if (sh_port[c] == r.port_key) begin
                  sh_idle[c] = '0;
                  o.found = 1'b1; o.thread_out = sh_thread[c]; o.addr_out = sh_addr[c];
                  o.local_out = sh_local[c]; o.round_trip_out = sh_rt[c];
                  o.tag_out = sh_tag[c];
                  break;
               end
         end
         FN_MATCH: begin
            p = END_LINK;
            for (c = sh_bucket[b]; c < END_LINK; c = sh_next[c]) begin
               if (sh_port[c] == r.port_key && sh_local[c] && sh_addr[c] == r.net_addr) begin
                  o.found = 1'b1; o.thread_out = sh_thread[c];
                  unlink_slot(b, p, c);
                  break;
               end
               p = c;
            end
         end
         FN_REMOVE: begin
            p = END_LINK;
            for (c = sh_bucket[b]; c < END_LINK; c = sh_next[c]) begin
               if (sh_port[c] == r.port_key && sh_addr[c] == r.net_addr &&
                   ((r.owner_only && sh_thread[c] == r.thread_id) || !sh_local[c])) begin
                  unlink_slot(b, p, c);
                  break;
               end
               p = c;
            end
         end
         FN_SWEEP: begin
            age_and_purge();
            o.remote_entries = 7'(sh_remote);
            o.oldest_out = sh_oldest;
         end
         default: ;
      endcase
      return o;
   endfunction

   // small pools so chains collide and entries get hit again
   logic [47:0] port_pool[8];
   logic [63:0] addr_pool[4];

   function automatic req_type pooled_beat(logic [2:0] f);
      req_type r;
      r = '0;
      r.func = f;
      r.port_key = port_pool[$urandom_range(7)];
      if ($urandom_range(9) == 0) r.port_key = 48'({$urandom, $urandom});
      r.net_addr = addr_pool[$urandom_range(3)];
      if ($urandom_range(9) == 0) r.net_addr = {$urandom, $urandom};
      r.thread_id = 16'($urandom_range(3));
      if ($urandom_range(7) == 0) r.thread_id = 16'($urandom);
      r.is_local = 1'($urandom_range(1));
      r.round_trip = $urandom;
      r.context_tag = $urandom;
      r.owner_only = 1'($urandom_range(1));
      return r;
   endfunction

   function automatic req_type fill_beat(int n, bit loc);
      req_type r;
      r = '0;
      r.func = FN_INSTALL;
      r.port_key = {40'($urandom), 8'(n)};
      r.net_addr = {$urandom, $urandom};
      r.thread_id = 16'($urandom);
      r.is_local = loc;
      r.round_trip = $urandom;
      r.context_tag = $urandom;
      return r;
   endfunction

   // driver
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            expected_rsps.push_back(cache_result(req_data));
            beats_in++;
         end
         if (!(req_valid && !req_ready)) begin
            if (pending_beats.size() > 0 && (quiet || $urandom_range(99) >= 33)) begin
               req_valid <= 1'b1;
               req_data <= pending_beats.pop_front();
            end else
               req_valid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            beats_out++;
            if (expected_rsps.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result beat %p", rsp_data);
            end else begin
               rsp_type e;
               e = expected_rsps.pop_front();
               if (e.found) hits++;
               if (e.status) full_fails++;
               if (rsp_data.remote_entries != 0 || rsp_data.oldest_out != 0) sweeps_seen++;
               if (rsp_data !== e) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch beat %0d: expected %p actual %p", beats_out, e, rsp_data);
               end
            end
         end
         rsp_ready <= !hold_off && (quiet || $urandom_range(99) >= 33);
      end
   end

   // watchdog
   int idle_cycles = 0;
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no beat for %0d cycles", idle_cycles);
         $display("FAILED: results differ");
         $finish;
      end
   end

   task automatic drain();
      while (pending_beats.size() > 0 || req_valid || expected_rsps.size() > 0)
         @(posedge clock);
   endtask

   initial begin
      req_type r;
      req_type local_fill[$];
      shadow_reset();
      for (int i = 0; i < 8; i++) port_pool[i] = 48'({$urandom, $urandom});
      port_pool[0] = '1;
      port_pool[1] = '0;
      port_pool[2][6:0] = port_pool[3][6:0];
      for (int i = 0; i < 4; i++) addr_pool[i] = {$urandom, $urandom};
      addr_pool[0] = '1;
      addr_pool[1] = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: miss, install, refresh, lookup, match, remove, sweep, unknown funcs
      pending_beats.push_back(pooled_beat(FN_LOOKUP));
      r = '1; r.func = FN_INSTALL;
      pending_beats.push_back(r);
      pending_beats.push_back(r);
      r.func = FN_LOOKUP; pending_beats.push_back(r);
      r.func = FN_MATCH;  pending_beats.push_back(r);
      r = '0; r.func = FN_INSTALL; pending_beats.push_back(r);
      r.func = FN_LOOKUP; pending_beats.push_back(r);
      r.func = FN_REMOVE; pending_beats.push_back(r);
      r.func = FN_SWEEP;  pending_beats.push_back(r);
      for (int f = 5; f < 8; f++) begin
         r = '1; r.func = 3'(f); pending_beats.push_back(r);
      end
      r = pooled_beat(FN_INSTALL); r.is_local = 1'b1; pending_beats.push_back(r);
      r.func = FN_REMOVE; r.owner_only = 1'b1; pending_beats.push_back(r);
      drain();

      // all-local full table: install fails
      for (int i = 0; i < ENTRIES; i++) begin
         r = fill_beat(i, 1'b1);
         local_fill.push_back(r);
         pending_beats.push_back(r);
      end
      pending_beats.push_back(fill_beat(200, 1'b0));
      drain();
      for (int i = 0; i < 16; i++) begin
         r = '0; r.func = FN_SWEEP; pending_beats.push_back(r);
      end
      for (int i = 0; i < 8; i++) pending_beats.push_back(pooled_beat(FN_INSTALL));
      // take the local entries out again
      foreach (local_fill[i]) begin
         r = local_fill[i]; r.func = FN_MATCH; pending_beats.push_back(r);
      end
      drain();

      // receiver holds off while sender keeps offering
      hold_off = 1'b1;
      fork
         begin
            repeat (400) @(posedge clock);
            hold_off = 1'b0;
         end
      join_none
      for (int i = 0; i < 12; i++) pending_beats.push_back(pooled_beat(3'($urandom_range(4))));
      drain();

      // random traffic; occasionally refill with remote entries to trigger eviction/purge
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         int pick;
         pick = $urandom_range(99);
         if (n == 400) quiet = 1'b1;
         if (n == 600) quiet = 1'b0;
         if (pick < 3) begin
            for (int i = 0; i < 50; i++) pending_beats.push_back(fill_beat(i, 1'b0));
            n += 50;
         end else if (pick < 40) pending_beats.push_back(pooled_beat(FN_INSTALL));
         else if (pick < 60) pending_beats.push_back(pooled_beat(FN_LOOKUP));
         else if (pick < 72) pending_beats.push_back(pooled_beat(FN_MATCH));
         else if (pick < 84) pending_beats.push_back(pooled_beat(FN_REMOVE));
         else if (pick < 97) pending_beats.push_back(pooled_beat(FN_SWEEP));
         else pending_beats.push_back(pooled_beat(3'($urandom_range(5, 7))));
         if (pending_beats.size() > 64) drain();
      end
      drain();
      repeat (2000) @(posedge clock);

      $display("covered %0d request beats, %0d result beats: %0d hits, %0d full-table failures,",
               beats_in, beats_out, hits, full_fails);
      $display("%0d sweeps with live remote entries, %0d mismatches", sweeps_seen, mismatches);
      if (mismatches == 0 && expected_rsps.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
